// ===== rtl/core/offgrid_heater_power_regulator_assert.svh =====
// assertion macros used by the heater power regulator top level
`ifndef OFFGRID_HEATER_POWER_REGULATOR_ASSERT_SVH
`define OFFGRID_HEATER_POWER_REGULATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define OHPR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define OHPR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/ohpr_pkg.sv =====
// shared constants, register indexes and control structs of the heater regulator
`default_nettype none

package ohpr_pkg;

   localparam int WATT_W     = 16;
   localparam int SAMPLE_W   = 18;
   localparam int TIME_W     = 32;
   localparam int PCT_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   // register reset values
   localparam logic [WATT_W-1:0]   RATING_RST    = 16'd2000;
   localparam logic [SAMPLE_W-1:0] BAT_LIMIT_RST = 18'd0;
   localparam logic [WATT_W-1:0]   INV_LIMIT_RST = 16'd3000;
   localparam logic [WATT_W-1:0]   STEP_RST      = 16'd100;
   localparam logic [WATT_W-1:0]   DELAY_RST     = 16'd1000;

   // percent scale and the quotient width it needs
   localparam int PCT_SCALE = 100;
   localparam int DVD_W     = 23;
   localparam int DIV_STEPS = DVD_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // floor(x / 10) as (x * WL_RECIP) >> WL_SHIFT, exact for x below 2^21
   localparam int WL_PROD_W = 20;
   localparam logic [WL_PROD_W-1:0] WL_RECIP = 20'hCCCCD;
   localparam int WL_SHIFT  = 23;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEATER_RATING  = 3'd0,
      CSR_BATTERY_LIMIT  = 3'd1,
      CSR_INVERTER_LIMIT = 3'd2,
      CSR_STEP_SIZE      = 3'd3,
      CSR_HOLD_DELAY     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic capture;
      logic check;
      logic apply;
      logic prep;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic trip;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/core/ohpr_datapath.sv =====
// registers, regulation arithmetic, serial percent divider and result register
`default_nettype none

module ohpr_datapath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [ohpr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ohpr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic signed [ohpr_pkg::SAMPLE_W-1:0] req_inverter_power,
   input  wire logic signed [ohpr_pkg::SAMPLE_W-1:0] req_battery_power,
   input  wire logic [ohpr_pkg::TIME_W-1:0]        req_time_ms,
   input  wire ohpr_pkg::cmd_type                  cmd,
   output ohpr_pkg::status_type                    status,
   output logic [ohpr_pkg::PCT_W-1:0]              rsp_power_percent,
   output logic [ohpr_pkg::WATT_W-1:0]             rsp_requested_watts,
   output logic                                    rsp_overpower_trip
);
   import ohpr_pkg::*;

   function automatic logic [WATT_W-1:0] clip16(input logic signed [SAMPLE_W:0] v);
      logic [WATT_W-1:0] r;
      if (v[SAMPLE_W]) begin
         r = '0;
      end else if (v[SAMPLE_W-1:WATT_W] != '0) begin
         r = '1;
      end else begin
         r = v[WATT_W-1:0];
      end
      return r;
   endfunction

   // configuration registers
   logic [WATT_W-1:0]          rating_ff, inv_limit_ff, step_ff, delay_ff;
   logic signed [SAMPLE_W-1:0] bat_limit_ff;
   logic [WATT_W-1:0]          work_limit_ff, work_limit_in;

   // regulation state
   logic [WATT_W-1:0] req_power_ff, req_power_in;
   logic [TIME_W-1:0] deadline_ff, deadline_in;

   // captured sample and check results
   logic signed [SAMPLE_W-1:0] inv_ff, bat_ff;
   logic [TIME_W-1:0]          now_ff;
   logic                       trip_ff, trip_in;
   logic                       over_ff, over_in;
   logic                       time_ok_ff, time_ok_in;
   logic [WATT_W-1:0]          corr_ff, corr_in;

   // divider
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [WATT_W-1:0] rem_ff, rem_in;

   // result register
   logic [PCT_W-1:0]  pct_ff, pct_in;
   logic [WATT_W-1:0] watts_ff;
   logic              otrip_ff;

   logic [WATT_W-1:0]          step_eff, delay_eff;
   logic [WL_PROD_W-1:0]       inv_x9;
   logic [2*WL_PROD_W-1:0]     wl_prod;
   logic signed [SAMPLE_W:0]   bat_over, inv_over;
   logic [WATT_W-1:0]          bat_clip, inv_clip, corr_a;
   logic [WATT_W:0]            inc_sum;
   logic [WATT_W:0]            rem_sh;
   logic                       q_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         rating_ff    <= RATING_RST;
         bat_limit_ff <= BAT_LIMIT_RST;
         inv_limit_ff <= INV_LIMIT_RST;
         step_ff      <= STEP_RST;
         delay_ff     <= DELAY_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_HEATER_RATING:  rating_ff    <= csr_wdata[WATT_W-1:0];
            CSR_BATTERY_LIMIT:  bat_limit_ff <= csr_wdata;
            CSR_INVERTER_LIMIT: inv_limit_ff <= csr_wdata[WATT_W-1:0];
            CSR_STEP_SIZE:      step_ff      <= csr_wdata[WATT_W-1:0];
            CSR_HOLD_DELAY:     delay_ff     <= csr_wdata[WATT_W-1:0];
            default: ;
         endcase
      end
   end

   // working inverter limit, 90 percent floored
   always_comb begin
      inv_x9        = {inv_limit_ff, 3'b000} + WL_PROD_W'(inv_limit_ff);
      wl_prod       = inv_x9 * WL_RECIP;
      work_limit_in = wl_prod[WL_SHIFT +: WATT_W];
   end

   always_ff @(posedge clock) begin
      work_limit_ff <= work_limit_in;
   end

   assign step_eff  = (step_ff == '0)  ? WATT_W'(1) : step_ff;
   assign delay_eff = (delay_ff == '0) ? WATT_W'(1) : delay_ff;

   // check: trip, overdraw, correction amount and hold deadline
   always_comb begin
      trip_in    = $signed({inv_ff[SAMPLE_W-1], inv_ff})
                   > $signed({3'b000, inv_limit_ff});
      bat_over   = $signed({bat_ff[SAMPLE_W-1], bat_ff})
                   - $signed({bat_limit_ff[SAMPLE_W-1], bat_limit_ff});
      inv_over   = $signed({inv_ff[SAMPLE_W-1], inv_ff})
                   - $signed({3'b000, work_limit_ff});
      over_in    = (!bat_over[SAMPLE_W] && bat_over != '0)
                   || (!inv_over[SAMPLE_W] && inv_over != '0);
      bat_clip   = clip16(bat_over);
      inv_clip   = clip16(inv_over);
      corr_a     = (bat_clip > step_eff) ? bat_clip : step_eff;
      corr_in    = (inv_clip > corr_a) ? inv_clip : corr_a;
      time_ok_in = now_ff >= deadline_ff;
   end

   // apply: update request and deadline
   always_comb begin
      req_power_in = req_power_ff;
      deadline_in  = deadline_ff;
      inc_sum      = {1'b0, req_power_ff} + {1'b0, step_eff};
      if (trip_ff) begin
         req_power_in = '0;
         deadline_in  = '0;
      end else if (over_ff) begin
         req_power_in = (req_power_ff > corr_ff) ? req_power_ff - corr_ff : '0;
      end else if (time_ok_ff && req_power_ff < rating_ff) begin
         req_power_in = (inc_sum > {1'b0, rating_ff}) ? rating_ff : inc_sum[WATT_W-1:0];
         deadline_in  = now_ff + TIME_W'(delay_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_power_ff <= '0;
         deadline_ff  <= '0;
      end else if (cmd.apply) begin
         req_power_ff <= req_power_in;
         deadline_ff  <= deadline_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         inv_ff <= req_inverter_power;
         bat_ff <= req_battery_power;
         now_ff <= req_time_ms;
      end
      if (cmd.check) begin
         trip_ff    <= trip_in;
         over_ff    <= over_in;
         time_ok_ff <= time_ok_in;
         corr_ff    <= corr_in;
      end
   end

   // restoring divider, one quotient bit a cycle
   always_comb begin
      rem_sh = {rem_ff, dvd_ff[DVD_W-1]};
      q_bit  = rem_sh >= {1'b0, rating_ff};
      rem_in = q_bit ? WATT_W'(rem_sh - {1'b0, rating_ff}) : rem_sh[WATT_W-1:0];
      dvd_in = {dvd_ff[DVD_W-2:0], q_bit};
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         dvd_ff <= DVD_W'(req_power_ff) * DVD_W'(PCT_SCALE);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   // percent: zero on a trip, full scale for a zero rating with a request, else floor of 1 and saturation
   always_comb begin
      if (trip_ff) begin
         pct_in = '0;
      end else if (rating_ff == '0) begin
         pct_in = (req_power_ff != '0) ? '1 : '0;
      end else if (dvd_ff[DVD_W-1:PCT_W] != '0) begin
         pct_in = '1;
      end else if (dvd_ff[PCT_W-1:0] == '0 && req_power_ff != '0) begin
         pct_in = PCT_W'(1);
      end else begin
         pct_in = dvd_ff[PCT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         pct_ff   <= pct_in;
         watts_ff <= req_power_ff;
         otrip_ff <= trip_ff;
      end
   end

   assign status.trip         = trip_ff;
   assign rsp_power_percent   = pct_ff;
   assign rsp_requested_watts = watts_ff;
   assign rsp_overpower_trip  = otrip_ff;

endmodule

`default_nettype wire

// ===== rtl/core/ohpr_ctrl.sv =====
// sequencer for one sample: capture, settle, check, apply, prep, divide, deliver; a trip skips prep and divide
`default_nettype none

module ohpr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire ohpr_pkg::status_type status,
   output ohpr_pkg::cmd_type         cmd
);
   import ohpr_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SETTLE = 7'b0000010,
      ST_CHECK  = 7'b0000100,
      ST_APPLY  = 7'b0001000,
      ST_PREP   = 7'b0010000,
      ST_DIVIDE = 7'b0100000,
      ST_OUTPUT = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              slot_free;
   logic              div_last;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign div_last  = cnt_ff == CNT_W'(DIV_STEPS - 1);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_SETTLE;
            end
         end
         ST_SETTLE: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_APPLY;
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = status.trip ? ST_OUTPUT : ST_PREP;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (div_last) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            cmd.out_load = slot_free;
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== rtl/core/offgrid_heater_power_regulator.sv =====
// top level of the off-grid heater power regulator
// usage:
//   req_ channel: one measurement item (inverter power, battery power, ms time)
//   rsp_ channel: one result item per request (percent, requested watts, trip)
//   csr_ port: write-only registers, written while the block is idle
// normal path from item accept to rsp_valid: settle, check, apply, prep,
//   23 divider steps, output load; an overpower trip skips the divider
// one item at a time: the next item is taken only after the current result
//   is loaded; the bit-serial percent divider takes one quotient bit per cycle
//   over a 23-bit dividend
// req_ready is high only while the sequencer waits for an item; a finished
//   result sits in the output register, so the next item is taken while the
//   receiver still holds off
// receiver stall: a finished result waits in the output stage until the
//   held one is taken, then loads
// reset: synchronous, clears the request, the hold deadline and rsp_valid,
//   and loads the register defaults (such as 2000 W rating, 3000 W inverter)
`default_nettype none
`include "offgrid_heater_power_regulator_assert.svh"

module offgrid_heater_power_regulator (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // measurement items
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [ohpr_pkg::SAMPLE_W-1:0] req_inverter_power,
   input  wire logic signed [ohpr_pkg::SAMPLE_W-1:0] req_battery_power,
   input  wire logic [ohpr_pkg::TIME_W-1:0]          req_time_ms,
   // result items
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [ohpr_pkg::PCT_W-1:0]                rsp_power_percent,
   output logic [ohpr_pkg::WATT_W-1:0]               rsp_requested_watts,
   output logic                                      rsp_overpower_trip,
   // register writes
   input  wire logic                                 csr_we,
   input  wire logic [ohpr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [ohpr_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ohpr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: one item at a time
   ohpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // registers, arithmetic, divider and output stage
   ohpr_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_inverter_power  (req_inverter_power),
      .req_battery_power   (req_battery_power),
      .req_time_ms         (req_time_ms),
      .cmd                 (cmd),
      .status              (status),
      .rsp_power_percent   (rsp_power_percent),
      .rsp_requested_watts (rsp_requested_watts),
      .rsp_overpower_trip  (rsp_overpower_trip)
   );

   // a trip result always reports a cleared request
   `OHPR_ASSERT_SAME(a_trip_clears, clock, reset, rsp_valid && rsp_overpower_trip, rsp_requested_watts == '0 && rsp_power_percent == '0, "trip result with nonzero drive")

   // a nonzero request never reads as zero percent
   `OHPR_ASSERT_SAME(a_pct_floor, clock, reset, rsp_valid && rsp_requested_watts != '0, rsp_power_percent != '0, "nonzero request reported as zero percent")

   // the sequencer goes busy right after taking an item
   `OHPR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "item taken while previous one in progress")

endmodule

`default_nettype wire

// ===== tb/offgrid_heater_power_regulator_tb.sv =====
// self-checking testbench for the off-grid heater power regulator
`timescale 1ns / 100ps

module offgrid_heater_power_regulator_tb;
   import ohpr_pkg::*;

   // cycles with no item moving on either channel before the run is abandoned
   localparam int STALL_LIMIT = 3000;
   localparam int RANDOM_PER_SETTING = 206;
   localparam int SETTING_COUNT = 9;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] inverter_power;
      logic signed [SAMPLE_W-1:0] battery_power;
      logic [TIME_W-1:0]          time_ms;
   } sample_type;

   typedef struct packed {
      logic [PCT_W-1:0]  power_percent;
      logic [WATT_W-1:0] requested_watts;
      logic              overpower_trip;
   } drive_type;

   typedef struct packed {
      logic [WATT_W-1:0]          heater_rating;
      logic signed [SAMPLE_W-1:0] battery_limit;
      logic [WATT_W-1:0]          inverter_limit;
      logic [WATT_W-1:0]          step_size;
      logic [WATT_W-1:0]          hold_delay;
   } csr_set_type;

   // dut ports; the inputs are all known from time zero
   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SAMPLE_W-1:0] req_inverter_power = '0;
   logic signed [SAMPLE_W-1:0] req_battery_power = '0;
   logic [TIME_W-1:0] req_time_ms = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [PCT_W-1:0] rsp_power_percent;
   logic [WATT_W-1:0] rsp_requested_watts;
   logic rsp_overpower_trip;
   logic csr_we = 1'b0;
   csr_index_type csr_index = CSR_HEATER_RATING;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // samples waiting to go out, expected drive results waiting to come back
   sample_type sample_q[$];
   drive_type drive_expect_q[$];
   sample_type on_bus;

   // mirror of the regulator: its registers and its two state words
   csr_set_type cfg;
   logic [WATT_W-1:0] heater_req;
   logic [TIME_W-1:0] hold_until;

   // sample time used to build the random items, mostly advanced with each one
   logic [TIME_W-1:0] sim_now_ms = '0;

   int req_gap_pct = 0;
   int rsp_hold_pct = 0;
   int items_open = 0;
   int samples_sent = 0;
   int results_seen = 0;
   int mismatches = 0;
   int settings_run = 0;
   int trips = 0;
   int cuts = 0;
   int raises = 0;
   int stall_cycles = 0;

   offgrid_heater_power_regulator dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_inverter_power  (req_inverter_power),
      .req_battery_power   (req_battery_power),
      .req_time_ms         (req_time_ms),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_power_percent   (rsp_power_percent),
      .rsp_requested_watts (rsp_requested_watts),
      .rsp_overpower_trip  (rsp_overpower_trip),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor: one sample in, the drive result it causes out
   // ------------------------------------------------------------------
   function automatic drive_type next_drive(sample_type s);
      drive_type d;
      int inv_w, bat_w, work_w, bat_over, inv_over, corr, step_w, raised, pct;
      logic [TIME_W-1:0] delay_w;
      inv_w = $signed(s.inverter_power);
      bat_w = $signed(s.battery_power);
      // zero step or zero delay behave as one
      step_w = (cfg.step_size == '0) ? 1 : int'(cfg.step_size);
      delay_w = (cfg.hold_delay == '0) ? 32'd1 : TIME_W'(cfg.hold_delay);
      // working limit is 90 percent of the inverter maximum, rounded down
      work_w = int'(cfg.inverter_limit) * 90 / PCT_SCALE;
      d = '0;
      // overpower: wipe the state and flag it, nothing else happens
      if (inv_w > int'(cfg.inverter_limit)) begin
         heater_req = '0;
         hold_until = '0;
         d.overpower_trip = 1'b1;
         trips++;
         return d;
      end
      bat_over = bat_w - int'($signed(cfg.battery_limit));
      inv_over = inv_w - work_w;
      if (bat_over > 0 || inv_over > 0) begin
         // cut by the larger of step and overdraw, the overdraw capped at 16 bits
         corr = step_w;
         if (bat_over > corr)
            corr = (bat_over > 65535) ? 65535 : bat_over;
         if (inv_over > corr)
            corr = (inv_over > 65535) ? 65535 : inv_over;
         heater_req = (int'(heater_req) > corr) ? WATT_W'(int'(heater_req) - corr) : '0;
         cuts++;
      end else if (s.time_ms >= hold_until && heater_req < cfg.heater_rating) begin
         // deadline passed: one step up, clamped to the rating, deadline re-armed
         raised = int'(heater_req) + step_w;
         if (raised > int'(cfg.heater_rating))
            raised = int'(cfg.heater_rating);
         heater_req = WATT_W'(raised);
         hold_until = s.time_ms + delay_w;
         raises++;
      end
      if (cfg.heater_rating == '0) begin
         pct = (heater_req != '0) ? 255 : 0;
      end else begin
         pct = int'(heater_req) * PCT_SCALE / int'(cfg.heater_rating);
         if (pct > 255)
            pct = 255;
         if (heater_req != '0 && pct == 0)
            pct = 1;
      end
      d.power_percent = PCT_W'(pct);
      d.requested_watts = heater_req;
      return d;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic int sat18(int v);
      if (v < -131072)
         return -131072;
      if (v > 131071)
         return 131071;
      return v;
   endfunction

   function automatic int pick(int lo, int hi);
      if (hi <= lo)
         return lo;
      return lo + int'($urandom_range(hi - lo, 0));
   endfunction

   function automatic csr_set_type settings(int rating, int bat, int inv, int stp, int dly);
      csr_set_type c;
      c.heater_rating = rating[WATT_W-1:0];
      c.battery_limit = bat[SAMPLE_W-1:0];
      c.inverter_limit = inv[WATT_W-1:0];
      c.step_size = stp[WATT_W-1:0];
      c.hold_delay = dly[WATT_W-1:0];
      return c;
   endfunction

   // random sample shaped around the current limits: mostly healthy readings
   // with the clock moving about one hold delay, then overdraws, trips, noise
   function automatic sample_type make_sample();
      sample_type s;
      int work_w, lim_w, step_w, inv_v, bat_v, kind;
      int unsigned dly, r;
      logic [31:0] rnd;
      work_w = int'(cfg.inverter_limit) * 90 / PCT_SCALE;
      lim_w = $signed(cfg.battery_limit);
      step_w = (cfg.step_size == '0) ? 1 : int'(cfg.step_size);
      dly = (cfg.hold_delay == '0) ? 1 : cfg.hold_delay;
      kind = $urandom_range(99);
      inv_v = pick(sat18(work_w - 4000), work_w);
      bat_v = pick(sat18(lim_w - 4000), lim_w);
      if (kind >= 60 && kind < 72)
         bat_v = sat18(lim_w + pick(1, (kind < 64) ? 140000 : 2 * step_w + 2));
      else if (kind >= 72 && kind < 82)
         inv_v = pick(work_w + 1, int'(cfg.inverter_limit));
      else if (kind >= 82 && kind < 90)
         inv_v = pick(int'(cfg.inverter_limit) + 1, 131071);
      s.inverter_power = inv_v[SAMPLE_W-1:0];
      s.battery_power = bat_v[SAMPLE_W-1:0];
      r = $urandom_range(99);
      if (r < 3)
         sim_now_ms = 32'hFFFF_FFFF - $urandom_range(3 * dly);
      else if (r < 6)
         sim_now_ms = $urandom;
      else
         sim_now_ms = sim_now_ms + $urandom_range(dly + dly / 2);
      s.time_ms = sim_now_ms;
      if (kind >= 90) begin
         // pure noise over every bit of every field
         rnd = $urandom;
         s.inverter_power = rnd[SAMPLE_W-1:0];
         rnd = $urandom;
         s.battery_power = rnd[SAMPLE_W-1:0];
         s.time_ms = $urandom;
      end
      return s;
   endfunction

   task automatic push_sample(int inv, int bat, logic [TIME_W-1:0] t_ms);
      sample_type s;
      s.inverter_power = inv[SAMPLE_W-1:0];
      s.battery_power = bat[SAMPLE_W-1:0];
      s.time_ms = t_ms;
      sample_q.push_back(s);
      items_open++;
   endtask

   // every item gives exactly one result, so no open item means idle
   task automatic wait_idle();
      while (items_open != 0)
         @(posedge clock);
   endtask

   // all five registers back to back, write enable dropped once at the end
   task automatic apply_settings(csr_set_type c);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_HEATER_RATING;
      csr_wdata <= CSR_DATA_W'(c.heater_rating);
      @(posedge clock);
      csr_index <= CSR_BATTERY_LIMIT;
      csr_wdata <= c.battery_limit;
      @(posedge clock);
      csr_index <= CSR_INVERTER_LIMIT;
      csr_wdata <= CSR_DATA_W'(c.inverter_limit);
      @(posedge clock);
      csr_index <= CSR_STEP_SIZE;
      csr_wdata <= CSR_DATA_W'(c.step_size);
      @(posedge clock);
      csr_index <= CSR_HOLD_DELAY;
      csr_wdata <= CSR_DATA_W'(c.hold_delay);
      @(posedge clock);
      csr_we <= 1'b0;
      cfg = c;
      settings_run++;
   endtask

   task automatic flag_mismatch(string msg);
      if (mismatches < 10)
         $display("mismatch at result %0d: %s", results_seen, msg);
      mismatches++;
   endtask

   // ------------------------------------------------------------------
   // driver: presents queued samples, predicts each one as it is taken
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            drive_expect_q.push_back(next_drive(on_bus));
            samples_sent++;
         end
         // a new item only once the current one is gone; valid held otherwise
         if (!req_valid || req_ready) begin
            if (sample_q.size() != 0 && $urandom_range(99) >= req_gap_pct) begin
               on_bus = sample_q.pop_front();
               req_valid <= 1'b1;
               req_inverter_power <= on_bus.inverter_power;
               req_battery_power <= on_bus.battery_power;
               req_time_ms <= on_bus.time_ms;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // monitor: takes results with random back-pressure, checks in order
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      drive_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (drive_expect_q.size() == 0) begin
               flag_mismatch($sformatf("result with no item pending, watts %0d",
                                       rsp_requested_watts));
            end else begin
               want = drive_expect_q.pop_front();
               items_open--;
               if (rsp_power_percent != want.power_percent)
                  flag_mismatch($sformatf("power_percent expected %0d, got %0d",
                                          want.power_percent, rsp_power_percent));
               if (rsp_requested_watts != want.requested_watts)
                  flag_mismatch($sformatf("requested_watts expected %0d, got %0d",
                                          want.requested_watts, rsp_requested_watts));
               if (rsp_overpower_trip != want.overpower_trip)
                  flag_mismatch($sformatf("overpower_trip expected %0d, got %0d",
                                          want.overpower_trip, rsp_overpower_trip));
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_hold_pct);
      end
   end

   // watchdog: ends the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("no item moved for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin
      csr_set_type plan [SETTING_COUNT];
      int p, k;
      // register defaults and cleared state, as after reset
      cfg = settings(int'(RATING_RST), int'($signed(BAT_LIMIT_RST)), int'(INV_LIMIT_RST),
                     int'(STEP_RST), int'(DELAY_RST));
      heater_req = '0;
      hold_until = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed, default registers: rise, hold, cuts, saturation, trips
      push_sample(0, -500, 32'd0);             // deadline zero, first step up
      push_sample(0, -500, 32'd999);           // still holding
      push_sample(0, -500, 32'd1000);          // deadline reached exactly
      push_sample(0, 50, 32'd1500);            // small battery overdraw, cut by step
      push_sample(0, -1, 32'd2000);
      push_sample(0, 131071, 32'd2100);        // huge overdraw, correction saturates
      push_sample(2701, -1, 32'd3100);         // one watt over the 90 percent limit
      push_sample(3000, -1, 32'd3200);         // at the inverter maximum, no trip
      push_sample(3001, 0, 32'd3300);          // one watt over: trip
      push_sample(131071, 0, 32'd3400);        // largest reading: trip
      push_sample(-131072, -131072, 32'd0);    // after trip the deadline is zero
      push_sample(-5, -5, 32'hFFFF_FF00);      // new deadline wraps past zero
      push_sample(-5, -5, 32'hFFFF_FFFF);
      push_sample(-5, -5, 32'd0);
      wait_idle();

      // zero step and zero delay act as one
      apply_settings(settings(2000, 0, 3000, 0, 0));
      push_sample(0, -1, 32'd10);
      push_sample(0, -1, 32'd10);
      push_sample(0, -1, 32'd11);
      push_sample(0, 1, 32'd12);
      wait_idle();

      // widest rating: a small request still shows at least one percent
      apply_settings(settings(65535, 0, 3000, 500, 1));
      push_sample(0, -1, 32'd20);
      push_sample(0, -1, 32'd21);
      wait_idle();

      // rating dropped below the request: no rise, percent saturates
      apply_settings(settings(50, 0, 3000, 500, 1));
      push_sample(0, -1, 32'd100000);
      push_sample(0, -1, 32'd200000);
      wait_idle();

      // zero rating: full scale while anything is requested, never rises
      apply_settings(settings(0, 0, 3000, 300, 1));
      push_sample(0, -1, 32'd300000);
      push_sample(0, 131071, 32'd300001);
      push_sample(0, -1, 32'd400000);
      wait_idle();

      // random part: three back-pressure regimes, three settings each
      plan[0] = settings(2000, 0, 3000, 100, 1000);
      plan[1] = settings(65535, 131071, 65535, 65535, 65535);
      plan[2] = settings(500, 1500, 5000, 37, 10);
      plan[3] = settings(1, -131072, 0, 0, 0);
      plan[4] = settings(0, 100, 2000, 250, 3);
      plan[5] = settings(40000, -200, 50000, 4000, 50);
      plan[6] = settings($urandom_range(65535, 1), pick(-131072, 131071),
                         $urandom_range(65535), $urandom_range(65535), $urandom_range(2000));
      plan[7] = settings(3000, 2000, 10000, 1, 0);
      plan[8] = settings($urandom_range(8000, 1), pick(-4000, 4000),
                         $urandom_range(12000), $urandom_range(600), $urandom_range(200));
      for (p = 0; p < SETTING_COUNT; p++) begin
         wait_idle();
         req_gap_pct = (p < 3) ? 8 : (p < 6) ? 79 : 0;
         rsp_hold_pct = (p < 3) ? 79 : (p < 6) ? 8 : 0;
         apply_settings(plan[p]);
         for (k = 0; k < RANDOM_PER_SETTING; k++) begin
            sample_q.push_back(make_sample());
            items_open++;
         end
      end

      // drain, then give a late or extra result time to show up
      wait_idle();
      repeat (40) @(posedge clock);

      $display("covered %0d samples over %0d register settings: %0d trips, %0d cuts, %0d rises",
               samples_sent, settings_run, trips, cuts, raises);
      $display("%0d results checked, %0d mismatches, %0d still expected",
               results_seen, mismatches, drive_expect_q.size());
      if (mismatches == 0 && drive_expect_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ohpr_pkg.sv
rtl/core/ohpr_datapath.sv
rtl/core/ohpr_ctrl.sv
rtl/core/offgrid_heater_power_regulator.sv
tb/offgrid_heater_power_regulator_tb.sv
